### hw/rtl/assert_macros.svh
// Assertion helpers used by the checker file npv_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check sampled on the rising clock edge, off while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");

// Implication check: whenever the trigger holds, the consequence holds too.
`define ASSERT_IMPL(label, clk, rst_n, trig, cons) \
	`ASSERT_CLK(label, clk, rst_n, (trig) |-> (cons))

`endif

### hw/rtl/npv_pkg.sv
`timescale 1ns / 1ps

package npv_pkg;

	// Verdict codes.
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_LENGTH    = 3'd1;
	localparam logic [2:0] ST_MISS_TAG  = 3'd2;
	localparam logic [2:0] ST_DISCRIM   = 3'd3;
	localparam logic [2:0] ST_SEC_HDR   = 3'd4;
	localparam logic [2:0] ST_MSG_TYPE  = 3'd5;
	localparam logic [2:0] ST_TOO_SHORT = 3'd6;

	// Header codes.
	localparam logic [7:0] EPD_MM       = 8'h7E;
	localparam logic [7:0] EPD_SM       = 8'h2E;
	localparam logic [3:0] SEC_SVC_REQ  = 4'hC;
	localparam logic [3:0] SEC_MAX_STD  = 4'h4;
	localparam logic [7:0] MT_MM_LO     = 8'h41;
	localparam logic [7:0] MT_MM_HI     = 8'h6F;
	localparam logic [7:0] MT_SM_LO     = 8'hC1;
	localparam logic [7:0] MT_SM_HI     = 8'hDF;
	localparam logic [7:0] MT_AUTH_REQ  = 8'h56;
	localparam int         HDR_BYTES    = 3;
	localparam int         AUTH_PAYLOAD = 35;

	// Register indexes of the configuration port.
	localparam logic REG_CHECK_TAGS = 1'b0;
	localparam logic REG_MAX_BYTES  = 1'b1;

	localparam int VB_W = 14;

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] tag_a;
		logic [7:0] tag_b;
	} npv_tags_t;

	// Header fields and tag flags after the current byte has been applied.
	typedef struct packed {
		logic [7:0] discrim;
		logic [3:0] sec_nibble;
		logic [7:0] hdr_type;
		logic [7:0] eff_type;
		logic [1:0] found;
	} npv_hdr_view_t;

	typedef struct packed {
		logic [2:0]      status;
		logic [7:0]      error_tag;
		logic [VB_W-1:0] checked_len;
	} npv_result_t;

	function automatic logic [5:0] min_length_of(input logic [7:0] t);
		logic [5:0] r;
		case (t)
			8'h41: r = 6'd20;
			8'h42: r = 6'd10;
			8'h43: r = 6'd5;
			8'h45: r = 6'd10;
			8'h56: r = 6'd35;
			8'h57: r = 6'd18;
			8'h5D: r = 6'd10;
			8'h5E: r = 6'd5;
			8'h67: r = 6'd10;
			8'h68: r = 6'd10;
			8'hC1: r = 6'd10;
			8'hC2: r = 6'd20;
			default: r = 6'd3;
		endcase
		return r;
	endfunction

	function automatic npv_tags_t tags_of(input logic [7:0] t);
		npv_tags_t r;
		r = '0;
		case (t)
			8'h41: r = '{count: 2'd2, tag_a: 8'h5E, tag_b: 8'h15};
			8'h42: r = '{count: 2'd1, tag_a: 8'h18, tag_b: 8'h00};
			8'h56: r = '{count: 2'd2, tag_a: 8'h21, tag_b: 8'h20};
			8'h5D: r = '{count: 2'd1, tag_a: 8'h30, tag_b: 8'h00};
			8'hC1: r = '{count: 2'd2, tag_a: 8'h12, tag_b: 8'h19};
			8'hC2: r = '{count: 2'd2, tag_a: 8'h12, tag_b: 8'h35};
			8'h67, 8'h68: r = '{count: 2'd2, tag_a: 8'h40, tag_b: 8'h41};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic sec_ok(input logic [3:0] n);
		return (n <= SEC_MAX_STD) || (n == SEC_SVC_REQ);
	endfunction

	function automatic logic type_ok(input logic [7:0] t);
		return ((t >= MT_MM_LO) && (t <= MT_MM_HI)) || ((t >= MT_SM_LO) && (t <= MT_SM_HI));
	endfunction

endpackage

### hw/rtl/npv_tracker.sv
`timescale 1ns / 1ps

// Per-PDU state: byte count, header bytes and the walk over tag-length items.
module npv_tracker #(
	parameter int MAX_PDU_BYTES = 8192,
	parameter int CW = $clog2(MAX_PDU_BYTES + 2)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic [7:0]             data_byte,
	input  logic                   last_byte,
	input  logic [7:0]             forced_type,
	output logic [CW-1:0]          len,
	output npv_pkg::npv_hdr_view_t view
);

	localparam int NW = $clog2(MAX_PDU_BYTES + 257);

	logic [CW-1:0] count_q, count_n, q_off;
	logic [7:0]    discrim_q, discrim_n;
	logic [3:0]    sec_q, sec_n;
	logic [7:0]    hdr_q, hdr_n;
	logic [7:0]    forced_q, forced_n;
	logic [NW-1:0] nto_q, nto_n;
	logic [NW:0]   nto_plus1;
	logic [1:0]    pend_q, pend_n;
	logic [1:0]    found_q, found_n;
	logic [7:0]    mt_q;
	npv_pkg::npv_tags_t tags;

	assign mt_q      = (forced_q != 8'd0) ? forced_q : hdr_q;
	assign tags      = npv_pkg::tags_of(mt_q);
	assign q_off     = count_q - CW'(npv_pkg::HDR_BYTES);
	assign nto_plus1 = {1'b0, nto_q} + (NW+1)'(1);

	// Next state for the byte at position count_q.
	always_comb begin
		discrim_n = discrim_q;
		sec_n     = sec_q;
		hdr_n     = hdr_q;
		forced_n  = forced_q;
		nto_n     = nto_q;
		pend_n    = pend_q;
		found_n   = found_q;
		if (count_q < CW'(MAX_PDU_BYTES)) begin
			if (count_q == CW'(0)) begin
				forced_n  = forced_type;
				discrim_n = data_byte;
			end else if (count_q == CW'(1)) begin
				sec_n = data_byte[3:0];
			end else if (count_q == CW'(2)) begin
				hdr_n = data_byte;
			end else if (NW'(q_off) == nto_q) begin
				// Tag position: remember which required tags match.
				pend_n[0] = (tags.count >= 2'd1) && (data_byte == tags.tag_a);
				pend_n[1] = (tags.count >= 2'd2) && (data_byte == tags.tag_b);
			end else if ((NW+1)'(q_off) == nto_plus1) begin
				// Length position: the tag counts, and the next item is located.
				found_n = found_q | pend_q;
				pend_n  = 2'b00;
				nto_n   = NW'(q_off) + NW'(1) + NW'(data_byte);
			end
		end
		count_n = (count_q < CW'(MAX_PDU_BYTES + 1)) ? count_q + CW'(1) : count_q;
	end

	assign len           = count_n;
	assign view.discrim    = discrim_n;
	assign view.sec_nibble = sec_n;
	assign view.hdr_type   = hdr_n;
	assign view.eff_type   = (forced_n != 8'd0) ? forced_n : hdr_n;
	assign view.found      = found_n;

	// State registers; everything returns to zero after the last byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			discrim_q <= '0;
			sec_q     <= '0;
			hdr_q     <= '0;
			forced_q  <= '0;
			nto_q     <= '0;
			pend_q    <= '0;
			found_q   <= '0;
		end else if (en) begin
			if (last_byte) begin
				count_q   <= '0;
				discrim_q <= '0;
				sec_q     <= '0;
				hdr_q     <= '0;
				forced_q  <= '0;
				nto_q     <= '0;
				pend_q    <= '0;
				found_q   <= '0;
			end else begin
				count_q   <= count_n;
				discrim_q <= discrim_n;
				sec_q     <= sec_n;
				hdr_q     <= hdr_n;
				forced_q  <= forced_n;
				nto_q     <= nto_n;
				pend_q    <= pend_n;
				found_q   <= found_n;
			end
		end
	end

endmodule

### hw/rtl/npv_verdict.sv
`timescale 1ns / 1ps

// Priority chain of checks that turns the PDU summary into one verdict.
module npv_verdict #(
	parameter int MAX_PDU_BYTES = 8192,
	parameter int CW = $clog2(MAX_PDU_BYTES + 2)
) (
	input  logic [CW-1:0]          len,
	input  npv_pkg::npv_hdr_view_t view,
	input  logic                   check_tags,
	input  logic [13:0]            max_bytes,
	output npv_pkg::npv_result_t   result
);

	localparam int XW = (CW > 14) ? CW : 14;

	logic [XW-1:0] len_x, max_x, limit_x;
	logic          short_for_type;
	npv_pkg::npv_tags_t tags;

	assign len_x   = XW'(len);
	assign max_x   = XW'(max_bytes);
	assign limit_x = (max_x > XW'(MAX_PDU_BYTES)) ? XW'(MAX_PDU_BYTES) : max_x;
	assign tags    = npv_pkg::tags_of(view.eff_type);

	// Authentication request also needs a full payload after the header.
	assign short_for_type = (len_x < XW'(npv_pkg::min_length_of(view.eff_type)))
		|| ((view.eff_type == npv_pkg::MT_AUTH_REQ)
			&& (len_x < XW'(npv_pkg::HDR_BYTES + npv_pkg::AUTH_PAYLOAD)));

	always_comb begin
		result = '0;
		if (len_x > limit_x) begin
			result.status = npv_pkg::ST_LENGTH;
		end else if (len_x < XW'(npv_pkg::HDR_BYTES)) begin
			result.status = npv_pkg::ST_TOO_SHORT;
		end else if ((view.discrim != npv_pkg::EPD_MM) && (view.discrim != npv_pkg::EPD_SM)) begin
			result.status    = npv_pkg::ST_DISCRIM;
			result.error_tag = npv_pkg::EPD_MM;
		end else if (!npv_pkg::sec_ok(view.sec_nibble)) begin
			result.status = npv_pkg::ST_SEC_HDR;
		end else if (!npv_pkg::type_ok(view.hdr_type)) begin
			result.status = npv_pkg::ST_MSG_TYPE;
		end else if (short_for_type) begin
			result.status      = npv_pkg::ST_LENGTH;
			result.checked_len = npv_pkg::VB_W'(npv_pkg::HDR_BYTES);
		end else if (check_tags && (tags.count >= 2'd1) && !view.found[0]) begin
			result.status      = npv_pkg::ST_MISS_TAG;
			result.error_tag   = tags.tag_a;
			result.checked_len = npv_pkg::VB_W'(npv_pkg::HDR_BYTES);
		end else if (check_tags && (tags.count >= 2'd2) && !view.found[1]) begin
			result.status      = npv_pkg::ST_MISS_TAG;
			result.error_tag   = tags.tag_b;
			result.checked_len = npv_pkg::VB_W'(npv_pkg::HDR_BYTES);
		end else begin
			result.checked_len = npv_pkg::VB_W'(len_x);
		end
	end

endmodule

### hw/rtl/nas_pdu_validator.sv
`timescale 1ns / 1ps

// NAS PDU header and required-tag checker.
// Input stream: one PDU byte per word on s_axis_tdata, tlast on the final
// byte, and the forced message type on s_axis_tuser (sampled with byte 0;
// zero means the type comes from header byte 2).
// Output stream: one verdict word per PDU (status, error_tag,
// checked_len), nothing for the other bytes.
// Configuration: cfg_index 0 enables the required-tag search, index 1 sets
// the longest accepted PDU; cfg_ready is always high.
// Throughput: one byte per cycle while no last byte waits on a stalled output, set
// by the single compare-and-add pass of the tag walk between the input register
// and the verdict register. The last byte passes the input register and then the
// result register before the verdict shows on m_axis_tvalid.
// Reset clears all per-PDU state and both registers to their defaults
// (tag search on, 8192 bytes). When the receiver stalls, the verdict holds;
// bytes keep flowing until the next last byte reaches the input register,
// which then waits for the output word to leave.
module nas_pdu_validator #(
	parameter int MAX_PDU_BYTES = 8192
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,
	input  logic [7:0]  s_axis_tuser,   // [7:0] forced_type
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [2:0] status, [10:3] error_tag, [24:11] checked_len
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [13:0] cfg_data
);

	localparam int CW = $clog2(MAX_PDU_BYTES + 2);

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [7:0]  forced_s1;
	logic        out_valid_q;
	npv_pkg::npv_result_t out_q;
	logic        check_tags_q;
	logic [13:0] max_bytes_q;
	logic        adv, consume;
	logic [CW-1:0] len;
	npv_pkg::npv_hdr_view_t view;
	npv_pkg::npv_result_t   result;

	// Handshake: a byte without tlast never waits on the output side.
	assign adv           = !out_valid_q || m_axis_tready;
	assign consume       = valid_s1 && (adv || !last_s1);
	assign s_axis_tready = !valid_s1 || consume;
	assign cfg_ready     = 1'b1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tvalid && s_axis_tready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			data_s1   <= s_axis_tdata;
			last_s1   <= s_axis_tlast;
			forced_s1 <= s_axis_tuser;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_tags_q <= 1'b1;
			max_bytes_q  <= 14'd8192;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				npv_pkg::REG_CHECK_TAGS: check_tags_q <= cfg_data[0];
				npv_pkg::REG_MAX_BYTES:  max_bytes_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	npv_tracker #(
		.MAX_PDU_BYTES(MAX_PDU_BYTES),
		.CW(CW)
	) u_tracker (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (consume),
		.data_byte   (data_s1),
		.last_byte   (last_s1),
		.forced_type (forced_s1),
		.len         (len),
		.view        (view)
	);

	npv_verdict #(
		.MAX_PDU_BYTES(MAX_PDU_BYTES),
		.CW(CW)
	) u_verdict (
		.len        (len),
		.view       (view),
		.check_tags (check_tags_q),
		.max_bytes  (max_bytes_q),
		.result     (result)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= consume && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && last_s1) begin
			out_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_q.checked_len, out_q.error_tag, out_q.status};

endmodule

### hw/rtl/npv_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the verdict stream.
module npv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	logic [2:0]  status;
	logic [7:0]  error_tag;
	logic [13:0] vbytes;
	logic        stall_word, ok_word, discrim_word, miss_word;

	assign status    = m_axis_tdata[2:0];
	assign error_tag = m_axis_tdata[10:3];
	assign vbytes    = m_axis_tdata[24:11];

	assign stall_word   = m_axis_tvalid && !m_axis_tready;
	assign ok_word      = m_axis_tvalid && (status == npv_pkg::ST_OK);
	assign discrim_word = m_axis_tvalid && (status == npv_pkg::ST_DISCRIM);
	assign miss_word    = m_axis_tvalid && (status == npv_pkg::ST_MISS_TAG);

	// A stalled verdict word stays put.
	`ASSERT_CLK(a_out_hold, clk, arst_n, stall_word |=> (m_axis_tvalid && $stable(m_axis_tdata)))

	// A passed PDU blames no tag and covers at least the header.
	`ASSERT_IMPL(a_ok_fields, clk, arst_n, ok_word, (error_tag == 8'd0) && (vbytes >= 14'd3))

	// A bad discriminator blames the mobility-management code and passes nothing.
	`ASSERT_IMPL(a_discrim_fields, clk, arst_n, discrim_word, (error_tag == npv_pkg::EPD_MM) && (vbytes == 14'd0))

	// A missing tag is named and only the header counts as checked.
	`ASSERT_IMPL(a_miss_fields, clk, arst_n, miss_word, (error_tag != 8'd0) && (vbytes == 14'd3))

endmodule

bind nas_pdu_validator npv_checker u_npv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### sim/tb_nas_pdu_validator.sv
`timescale 1ns / 1ps

module tb_nas_pdu_validator;

	localparam int MAX_BYTES    = 8192;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE       = 6;
	localparam int PHASE_BYTES  = 130;
	localparam int CYCLE_LIMIT  = 100000;

	// Message types with a minimum length or required tags.
	localparam logic [7:0] KNOWN_TYPES [12] = '{8'h41, 8'h42, 8'h43, 8'h45, 8'h56, 8'h57,
		8'h5D, 8'h5E, 8'h67, 8'h68, 8'hC1, 8'hC2};

	// Register settings walked by the random part: {tag search, longest PDU}.
	localparam logic [14:0] PHASE_CFG [8] = '{{1'b0, 14'd8192}, {1'b1, 14'd16383},
		{1'b1, 14'd40}, {1'b0, 14'd3}, {1'b1, 14'd0}, {1'b1, 14'd8191},
		{1'b0, 14'd20}, {1'b1, 14'd8192}};

	// One directed PDU: length, forced type, first 12 bytes (byte 0 leftmost,
	// later bytes are zero) and an optional typed verdict.
	typedef struct packed {
		logic [7:0]           n;
		logic [7:0]           forced;
		logic [95:0]          head;
		logic                 typed;
		npv_pkg::npv_result_t want;
	} pdu_row_t;

	typedef struct packed {
		logic                 typed;
		npv_pkg::npv_result_t want;
	} verdict_pin_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] data_byte
	logic        s_axis_tlast = 1'b0;
	logic [7:0]  s_axis_tuser = 8'h00;   // [7:0] forced_type
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;           // [2:0] status, [10:3] error_tag, [24:11] checked_len
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = npv_pkg::REG_CHECK_TAGS;
	logic [13:0] cfg_data = 14'd0;

	nas_pdu_validator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #1 clk = ~clk;

	// Shadow copy of the registers and of the per-PDU state.
	logic        tags_on = 1'b1;
	logic [13:0] longest_pdu = 14'd8192;
	logic [13:0] rx_count = '0;
	logic [7:0]  rx_epd = '0;
	logic [3:0]  rx_sec = '0;
	logic [7:0]  rx_hdr_type = '0;
	logic [7:0]  rx_forced = '0;
	logic [13:0] tag_pos = '0;
	logic [1:0]  tag_pending = '0;
	logic [1:0]  tag_found = '0;

	npv_pkg::npv_result_t verdicts_due [$];
	verdict_pin_t         verdict_pins [$];
	logic [7:0]           pdu_buf [$];
	pdu_row_t             dir_rows [$];
	int                   mismatch_count = 0;
	int                   burst_left = 0;
	logic                 hold_off_req = 1'b0;
	int unsigned          cycle_count = 0;

	function automatic logic [13:0] shortest_pdu(input logic [7:0] t);
		case (t)
			8'h41, 8'hC2: return 14'd20;
			8'h42, 8'h45, 8'h5D, 8'h67, 8'h68, 8'hC1: return 14'd10;
			8'h43, 8'h5E: return 14'd5;
			8'h56: return 14'd35;
			8'h57: return 14'd18;
			default: return 14'd3;
		endcase
	endfunction

	// Number of tags a message type must carry, and which ones.
	function automatic logic [1:0] required_tags(input logic [7:0] t,
			output logic [7:0] a, output logic [7:0] b);
		a = 8'h00;
		b = 8'h00;
		case (t)
			8'h41: begin a = 8'h5E; b = 8'h15; return 2'd2; end
			8'h42: begin a = 8'h18; return 2'd1; end
			8'h56: begin a = 8'h21; b = 8'h20; return 2'd2; end
			8'h5D: begin a = 8'h30; return 2'd1; end
			8'hC1: begin a = 8'h12; b = 8'h19; return 2'd2; end
			8'hC2: begin a = 8'h12; b = 8'h35; return 2'd2; end
			8'h67, 8'h68: begin a = 8'h40; b = 8'h41; return 2'd2; end
			default: return 2'd0;
		endcase
	endfunction

	// Takes one accepted byte; returns 1 with the verdict on the last byte.
	function automatic logic step_pdu_byte(input logic [7:0] d, input logic l,
			input logic [7:0] f, output npv_pkg::npv_result_t v);
		logic [13:0] q;
		logic [13:0] lim;
		logic [7:0]  mt;
		logic [7:0]  ta;
		logic [7:0]  tb;
		logic [1:0]  nt;
		v = '0;
		if (rx_count < MAX_BYTES) begin
			if (rx_count == 0) begin
				rx_forced = f;
				rx_epd = d;
			end else if (rx_count == 1) begin
				rx_sec = d[3:0];
			end else if (rx_count == 2) begin
				rx_hdr_type = d;
			end else begin
				// Tag walk over the payload: a tag byte, then its length byte.
				q = rx_count - 14'd3;
				mt = (rx_forced != 0) ? rx_forced : rx_hdr_type;
				if (q == tag_pos) begin
					nt = required_tags(mt, ta, tb);
					tag_pending = {(nt >= 2) && (d == tb), (nt >= 1) && (d == ta)};
				end else if (q == tag_pos + 14'd1) begin
					tag_found = tag_found | tag_pending;
					tag_pending = '0;
					tag_pos = q + 14'd1 + d;
				end
			end
		end
		if (rx_count < MAX_BYTES + 1) rx_count = rx_count + 14'd1;
		if (!l) return 1'b0;

		lim = (longest_pdu > MAX_BYTES) ? 14'(MAX_BYTES) : longest_pdu;
		mt = (rx_forced != 0) ? rx_forced : rx_hdr_type;
		nt = required_tags(mt, ta, tb);
		if (rx_count > lim) begin
			v.status = npv_pkg::ST_LENGTH;
		end else if (rx_count < npv_pkg::HDR_BYTES) begin
			v.status = npv_pkg::ST_TOO_SHORT;
		end else if (rx_epd != npv_pkg::EPD_MM && rx_epd != npv_pkg::EPD_SM) begin
			v.status = npv_pkg::ST_DISCRIM;
			v.error_tag = npv_pkg::EPD_MM;
		end else if (!(rx_sec <= npv_pkg::SEC_MAX_STD || rx_sec == npv_pkg::SEC_SVC_REQ)) begin
			v.status = npv_pkg::ST_SEC_HDR;
		end else if (!((rx_hdr_type >= npv_pkg::MT_MM_LO && rx_hdr_type <= npv_pkg::MT_MM_HI) ||
				(rx_hdr_type >= npv_pkg::MT_SM_LO && rx_hdr_type <= npv_pkg::MT_SM_HI))) begin
			v.status = npv_pkg::ST_MSG_TYPE;
		end else if (rx_count < shortest_pdu(mt) || (mt == npv_pkg::MT_AUTH_REQ &&
				rx_count - npv_pkg::HDR_BYTES < npv_pkg::AUTH_PAYLOAD)) begin
			v.status = npv_pkg::ST_LENGTH;
			v.checked_len = 14'(npv_pkg::HDR_BYTES);
		end else if (tags_on && nt >= 1 && !tag_found[0]) begin
			v.status = npv_pkg::ST_MISS_TAG;
			v.error_tag = ta;
			v.checked_len = 14'(npv_pkg::HDR_BYTES);
		end else if (tags_on && nt >= 2 && !tag_found[1]) begin
			v.status = npv_pkg::ST_MISS_TAG;
			v.error_tag = tb;
			v.checked_len = 14'(npv_pkg::HDR_BYTES);
		end else begin
			v.status = npv_pkg::ST_OK;
			v.checked_len = rx_count;
		end

		// Every verdict starts the next PDU from a clean state.
		rx_count = '0;
		rx_epd = '0;
		rx_sec = '0;
		rx_hdr_type = '0;
		rx_forced = '0;
		tag_pos = '0;
		tag_pending = '0;
		tag_found = '0;
		return 1'b1;
	endfunction

	// Handshake monitor: register writes, accepted bytes, verdict words.
	always @(posedge clk) begin
		npv_pkg::npv_result_t v;
		npv_pkg::npv_result_t got;
		verdict_pin_t         pin;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == npv_pkg::REG_CHECK_TAGS) tags_on = cfg_data[0];
				else longest_pdu = cfg_data;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				if (step_pdu_byte(s_axis_tdata, s_axis_tlast, s_axis_tuser, v)) begin
					pin = verdict_pins.pop_front();
					verdicts_due.push_back(pin.typed ? pin.want : v);
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = m_axis_tdata[2:0];
				got.error_tag = m_axis_tdata[10:3];
				got.checked_len = m_axis_tdata[24:11];
				if (verdicts_due.size() == 0) begin
					$error("verdict word with none pending: %h", m_axis_tdata);
					mismatch_count++;
				end else begin
					v = verdicts_due.pop_front();
					if (got.status != v.status) begin
						$error("status: expected %0d, got %0d", v.status, got.status);
						mismatch_count++;
					end
					if (got.error_tag != v.error_tag) begin
						$error("error_tag: expected %h, got %h", v.error_tag, got.error_tag);
						mismatch_count++;
					end
					if (got.checked_len != v.checked_len) begin
						$error("checked_len: expected %0d, got %0d",
							v.checked_len, got.checked_len);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// Receiver: stretches of steady, sparse, dense or periodic stalls, and one
	// long hold-off on request.
	initial begin
		int mode;
		int run;
		int k;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			mode = $urandom_range(0, 3);
			run = $urandom_range(8, 60);
			for (k = 0; k < run; k++) begin
				case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= ($urandom_range(0, 3) != 0);
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (k % 3 != 2);
				endcase
				@(posedge clk);
			end
		end
	end

	// Offers one byte, opening a new burst after a random gap when the
	// current one is used up; returns at the edge that takes the byte.
	task automatic put_byte(input logic [7:0] d, input logic l, input logic [7:0] u);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 160 : 20);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= d;
		s_axis_tlast <= l;
		s_axis_tuser <= u;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// Sends pdu_buf as one PDU; tuser only matters on byte 0.
	task automatic send_pdu(input logic [7:0] forced, input logic typed,
			input npv_pkg::npv_result_t want);
		int i;
		verdict_pins.push_back(verdict_pin_t'{typed, want});
		for (i = 0; i < pdu_buf.size(); i++)
			put_byte(pdu_buf[i], i == pdu_buf.size() - 1,
				(i == 0) ? forced : 8'($urandom_range(0, 255)));
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// One register write; cfg_valid is dropped again before the task returns.
	task automatic write_reg(input logic idx, input logic [13:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] random_valid_type();
		if ($urandom_range(0, 1)) return 8'($urandom_range(npv_pkg::MT_MM_LO, npv_pkg::MT_MM_HI));
		return 8'($urandom_range(npv_pkg::MT_SM_LO, npv_pkg::MT_SM_HI));
	endfunction

	// Fills pdu_buf: mostly well-formed PDUs whose payload walks real
	// tag-length items, plus noise and PDUs with a broken header or length.
	task automatic build_random_pdu(output logic [7:0] forced);
		int kind;
		int pick;
		int target;
		logic [7:0] mt;
		logic [7:0] hdr;
		logic [7:0] eff;
		logic [7:0] ta;
		logic [7:0] tb;
		logic [7:0] len;
		pdu_buf.delete();
		kind = $urandom_range(0, 9);
		forced = 8'h00;
		if (kind == 0) begin
			forced = 8'($urandom_range(0, 255));
			repeat ($urandom_range(1, 12)) pdu_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			pick = $urandom_range(0, 13);
			mt = (pick < 12) ? KNOWN_TYPES[4'(pick)] : random_valid_type();
			hdr = mt;
			pick = $urandom_range(0, 9);
			if (pick == 8) begin
				forced = mt;
				hdr = random_valid_type();
			end else if (pick == 9) begin
				forced = 8'($urandom_range(0, 255));
			end
			eff = (forced != 0) ? forced : hdr;
			void'(required_tags(eff, ta, tb));

			pdu_buf.push_back($urandom_range(0, 1) ? npv_pkg::EPD_MM : npv_pkg::EPD_SM);
			pick = $urandom_range(0, 5);
			pdu_buf.push_back({4'($urandom_range(0, 15)),
				(pick == 5) ? npv_pkg::SEC_SVC_REQ : 4'(pick)});
			pdu_buf.push_back(hdr);

			target = shortest_pdu(eff) + $urandom_range(0, 14);
			if (eff == npv_pkg::MT_AUTH_REQ) target += npv_pkg::HDR_BYTES;
			if ($urandom_range(0, 9) == 0) target = $urandom_range(npv_pkg::HDR_BYTES, target);
			while (pdu_buf.size() < target) begin
				pick = $urandom_range(0, 3);
				pdu_buf.push_back((pick == 0) ? ta : (pick == 1) ? tb :
					8'($urandom_range(0, 255)));
				len = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) :
					8'($urandom_range(0, 3));
				pdu_buf.push_back(len);
				repeat (len) pdu_buf.push_back(8'($urandom_range(0, 255)));
			end
			while (pdu_buf.size() > target) void'(pdu_buf.pop_back());

			if (kind == 1) begin
				pick = $urandom_range(0, 3);
				if (pick < 3) pdu_buf[pick] = 8'($urandom_range(0, 255));
				else while (pdu_buf.size() > 1 && $urandom_range(0, 3) != 0)
					void'(pdu_buf.pop_back());
			end
		end
	endtask

	function automatic pdu_row_t pdu_case(input int n, input logic [7:0] forced,
			input logic [95:0] head, input int typed, input logic [2:0] st,
			input logic [7:0] tag, input int vb);
		return '{n: 8'(n), forced: forced, head: head, typed: (typed != 0),
			want: '{status: st, error_tag: tag, checked_len: 14'(vb)}};
	endfunction

	// Stimulus: directed PDUs, then random phases over register settings.
	initial begin
		pdu_row_t   row;
		logic [7:0] forced;
		int         i;
		int         ph;
		int         sent;

		dir_rows = '{
			pdu_case(1,  8'h00, 96'h7E_00_00_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_TOO_SHORT, 8'h00, 0),
			pdu_case(2,  8'h00, 96'h7E_00_00_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_TOO_SHORT, 8'h00, 0),
			pdu_case(3,  8'h00, 96'h7E_00_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(3,  8'h00, 96'h00_00_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_DISCRIM, npv_pkg::EPD_MM, 0),
			pdu_case(3,  8'h00, 96'hFF_00_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_DISCRIM, npv_pkg::EPD_MM, 0),
			pdu_case(3,  8'h00, 96'h2E_0C_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(3,  8'h00, 96'h7E_F4_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(3,  8'h00, 96'h7E_05_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_SEC_HDR, 8'h00, 0),
			pdu_case(3,  8'h00, 96'h7E_0F_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_SEC_HDR, 8'h00, 0),
			pdu_case(3,  8'h00, 96'h7E_00_40_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MSG_TYPE, 8'h00, 0),
			pdu_case(3,  8'h00, 96'h7E_00_6F_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(3,  8'h00, 96'h2E_00_DF_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(3,  8'h00, 96'h7E_00_E0_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MSG_TYPE, 8'h00, 0),
			pdu_case(3,  8'h44, 96'h7E_00_00_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MSG_TYPE, 8'h00, 0),
			pdu_case(19, 8'h00, 96'h7E_00_41_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_LENGTH, 8'h00, 3),
			pdu_case(20, 8'h00, 96'h7E_00_41_5E_01_00_15_01_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 20),
			pdu_case(20, 8'h00, 96'h7E_00_41_5E_01_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MISS_TAG, 8'h15, 3),
			pdu_case(20, 8'h00, 96'h7E_00_41_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MISS_TAG, 8'h5E, 3),
			pdu_case(37, 8'h00, 96'h7E_00_56_21_00_20_00_00_00_00_00_00, 1,
				npv_pkg::ST_LENGTH, 8'h00, 3),
			pdu_case(38, 8'h00, 96'h7E_00_56_21_00_20_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 38),
			pdu_case(10, 8'h42, 96'h7E_00_44_18_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 10),
			// A tag on the last byte has no length byte after it.
			pdu_case(10, 8'h00, 96'h7E_00_42_00_00_00_00_00_00_18_00_00, 1,
				npv_pkg::ST_MISS_TAG, 8'h18, 3),
			// The tag value sits in a length position only.
			pdu_case(10, 8'h00, 96'h7E_00_42_01_18_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_MISS_TAG, 8'h18, 3),
			pdu_case(5,  8'h41, 96'h7E_00_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_LENGTH, 8'h00, 3),
			pdu_case(3,  8'h01, 96'h7E_00_44_00_00_00_00_00_00_00_00_00, 1,
				npv_pkg::ST_OK, 8'h00, 3),
			pdu_case(12, 8'h00, 96'h7E_00_67_40_02_AA_BB_41_00_FF_FF_41, 0,
				npv_pkg::ST_OK, 8'h00, 0),
			pdu_case(12, 8'h00, 96'h2E_03_C1_12_01_55_19_00_00_00_00_00, 0,
				npv_pkg::ST_OK, 8'h00, 0)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed PDUs under the reset register values.
		foreach (dir_rows[r]) begin
			row = dir_rows[r];
			pdu_buf.delete();
			for (i = 0; i < row.n; i++)
				pdu_buf.push_back((i < 12) ? row.head[8 * (11 - i) +: 8] : 8'h00);
			send_pdu(row.forced, row.typed, row.want);
		end
		drain();

		// Random phases, one register setting each.
		for (ph = 0; ph < 8; ph++) begin
			write_reg(npv_pkg::REG_CHECK_TAGS, {13'd0, PHASE_CFG[3'(ph)][14]});
			write_reg(npv_pkg::REG_MAX_BYTES, PHASE_CFG[3'(ph)][13:0]);
			if (ph == 1) hold_off_req = 1'b1;
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_random_pdu(forced);
				send_pdu(forced, 1'b0, '0);
				sent += pdu_buf.size();
			end
			drain();
		end

		if (mismatch_count == 0 && verdicts_due.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
